>>> rtl/uvcr_pkg.sv
package uvcr_pkg;

  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int VERT_SPACE = 1 << IDX_W;
  localparam int MAX_VERTS_DEF = 1024;
  localparam int ROW_SHIFT  = 6;
  localparam int ROW_BITS   = 1 << ROW_SHIFT;
  localparam int PC_W       = ROW_SHIFT + 1;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_MARK   = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  localparam logic REG_VCOUNT  = 1'b0;
  localparam logic REG_COMPACT = 1'b1;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [IDX_W-1:0] vertex_index;
  } req_t;

  typedef struct packed {
    logic             is_used;
    logic [IDX_W-1:0] new_index;
    logic [CNT_W-1:0] kept_count;
    logic             index_error;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_SCAN
  } state_t;

  function automatic logic [PC_W-1:0] popcount(input logic [ROW_BITS-1:0] word);
    logic [PC_W-1:0] n;
    n = '0;
    for (int i = 0; i < ROW_BITS; i++) begin
      n = n + PC_W'(word[i]);
    end
    return n;
  endfunction

endpackage

>>> rtl/uvcr_bitmap.sv
module uvcr_bitmap #(
  parameter int ROWS  = 16,
  parameter int ROW_W = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          rd_en,
  input  logic [ROW_W-1:0]              rd_addr,
  output logic [uvcr_pkg::ROW_BITS-1:0] rd_word,
  input  logic                          wr_en,
  input  logic [ROW_W-1:0]              wr_addr,
  input  logic [uvcr_pkg::ROW_BITS-1:0] wr_data
);

  logic [uvcr_pkg::ROW_BITS-1:0] mem [ROWS];
  logic [uvcr_pkg::ROW_BITS-1:0] rd_data;
  logic [ROWS-1:0]               row_valid;
  logic                          rd_vld;

  // rows never written since the last clear read as zero
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (clear) begin
        row_valid <= '0;
      end else if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= row_valid[rd_addr];
      end
    end
  end

  assign rd_word = rd_vld ? rd_data : '0;

endmodule

>>> rtl/unused_vertex_compaction_remap_top.sv
// Used-vertex bitmap with compacted index lookup. Requests are taken when start is high
// and busy low; each gives exactly one result, shown on rsp for one cycle with done high,
// and the receiver cannot stall it. Clear, rejected and unknown requests are answered from
// idle; a mark does a read-modify-write of a 64-bit bitmap row. A lookup with compaction
// on walks the bitmap rows from row 0 to the row of the index, one row read and one
// 64-bit population count per cycle through the single read port of the bitmap memory.
// With compaction off a lookup reads only the row of the index. Clearing marks every row
// empty through a valid flag per row, so no sweep is needed after reset.
module unused_vertex_compaction_remap_top #(
  parameter int MAX_VERTS = uvcr_pkg::MAX_VERTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  uvcr_pkg::req_t    req,
  output logic              done,
  output uvcr_pkg::rsp_t    rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int DEPTH = (MAX_VERTS < uvcr_pkg::VERT_SPACE) ? MAX_VERTS : uvcr_pkg::VERT_SPACE;
  localparam int ROWS  = (DEPTH + uvcr_pkg::ROW_BITS - 1) / uvcr_pkg::ROW_BITS;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IW    = uvcr_pkg::IDX_W;
  localparam int CW    = uvcr_pkg::CNT_W;
  localparam int RB    = uvcr_pkg::ROW_BITS;

  uvcr_pkg::state_t state, state_next;
  logic [IW-1:0]    cur_idx, cur_idx_next;
  logic [IW-1:0]    acc, acc_next;
  logic [ROW_W-1:0] scan_row, scan_row_next;
  logic [CW-1:0]    total, total_next;
  logic             done_next;
  uvcr_pkg::rsp_t   rsp_next;
  logic [CW-1:0]    vertex_count;
  logic             compact_enable;

  logic             bm_clear;
  logic             rd_en;
  logic [ROW_W-1:0] rd_addr;
  logic [RB-1:0]    rd_word;
  logic             wr_en;
  logic [RB-1:0]    wr_data;

  logic             in_valid;
  logic [ROW_W-1:0] in_row;
  logic [ROW_W-1:0] cur_row;
  logic [uvcr_pkg::ROW_SHIFT-1:0] cur_off;
  logic [RB-1:0]    bit_mask;
  logic             hit;
  logic [IW-1:0]    cnt;
  logic             cfg_wr;

  assign in_valid = ({1'b0, req.vertex_index} < vertex_count)
                    && (32'(req.vertex_index) < MAX_VERTS);
  assign in_row   = ROW_W'(req.vertex_index >> uvcr_pkg::ROW_SHIFT);
  assign cur_row  = ROW_W'(cur_idx >> uvcr_pkg::ROW_SHIFT);
  assign cur_off  = cur_idx[uvcr_pkg::ROW_SHIFT-1:0];
  assign bit_mask = RB'(1) << cur_off;
  assign hit      = rd_word[cur_off];
  assign cnt      = acc + IW'(uvcr_pkg::popcount(rd_word & (bit_mask - RB'(1))));
  assign busy     = (state != uvcr_pkg::ST_IDLE);

  uvcr_bitmap #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W)
  ) u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .clear   (bm_clear),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_word (rd_word),
    .wr_en   (wr_en),
    .wr_addr (cur_row),
    .wr_data (wr_data)
  );

  always_comb begin
    state_next    = state;
    cur_idx_next  = cur_idx;
    acc_next      = acc;
    scan_row_next = scan_row;
    total_next    = total;
    done_next     = 1'b0;
    rsp_next      = rsp;
    bm_clear      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = in_row;
    wr_en         = 1'b0;
    wr_data       = rd_word | bit_mask;
    case (state)
      uvcr_pkg::ST_IDLE: begin
        if (start) begin
          cur_idx_next = req.vertex_index;
          acc_next     = '0;
          rsp_next     = '0;
          rsp_next.kept_count = total;
          case (req.req_type)
            uvcr_pkg::REQ_CLEAR: begin
              bm_clear   = 1'b1;
              total_next = '0;
              rsp_next.kept_count = '0;
              done_next  = 1'b1;
            end
            uvcr_pkg::REQ_MARK: begin
              if (in_valid) begin
                rd_en      = 1'b1;
                state_next = uvcr_pkg::ST_MARK;
              end else begin
                rsp_next.index_error = 1'b1;
                done_next = 1'b1;
              end
            end
            uvcr_pkg::REQ_LOOKUP: begin
              if (in_valid) begin
                rd_en         = 1'b1;
                rd_addr       = compact_enable ? '0 : in_row;
                scan_row_next = rd_addr;
                state_next    = uvcr_pkg::ST_SCAN;
              end else begin
                rsp_next.index_error = 1'b1;
                done_next = 1'b1;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      uvcr_pkg::ST_MARK: begin
        wr_en = 1'b1;
        if (!hit) begin
          total_next = total + CW'(1);
        end
        rsp_next            = '0;
        rsp_next.is_used    = 1'b1;
        rsp_next.kept_count = total_next;
        done_next  = 1'b1;
        state_next = uvcr_pkg::ST_IDLE;
      end
      uvcr_pkg::ST_SCAN: begin
        if (scan_row == cur_row) begin
          rsp_next            = '0;
          rsp_next.is_used    = hit;
          rsp_next.kept_count = total;
          if (!compact_enable) begin
            rsp_next.new_index = cur_idx;
          end else if (hit) begin
            rsp_next.new_index = cnt;
          end
          done_next  = 1'b1;
          state_next = uvcr_pkg::ST_IDLE;
        end else begin
          acc_next      = acc + IW'(uvcr_pkg::popcount(rd_word));
          scan_row_next = scan_row + ROW_W'(1);
          rd_en         = 1'b1;
          rd_addr       = scan_row_next;
        end
      end
      default: begin
        state_next = uvcr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uvcr_pkg::ST_IDLE;
      total <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      total <= total_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_idx  <= cur_idx_next;
    acc      <= acc_next;
    scan_row <= scan_row_next;
    rsp      <= rsp_next;
  end

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count   <= CW'(uvcr_pkg::VERT_SPACE);
      compact_enable <= 1'b1;
    end else if (cfg_wr) begin
      if (paddr[2] == uvcr_pkg::REG_VCOUNT) begin
        vertex_count <= pwdata[CW-1:0];
      end else begin
        compact_enable <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == uvcr_pkg::REG_COMPACT) ? {31'd0, compact_enable}
                                                       : {{(32-CW){1'b0}}, vertex_count};

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done || busy)
    else $error("accepted transfer neither answered nor in progress");

  a_err_not_used: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.is_used && rsp.index_error))
    else $error("error result reports a used vertex");

  a_err_zero_index: assert property (@(posedge clk) disable iff (rst)
    done && rsp.index_error |-> rsp.new_index == '0)
    else $error("error result carries a new index");

  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.kept_count <= CW'(uvcr_pkg::VERT_SPACE))
    else $error("kept count above vertex space");

  a_mark_count: assert property (@(posedge clk) disable iff (rst)
    state == uvcr_pkg::ST_MARK |=> total == $past(total) || total == $past(total) + CW'(1))
    else $error("mark changed the total by more than one");

endmodule
